[rtl/ordered_key_set_successor_unit_macros.svh]
// Assertion macros used by the ordered key set RTL.
`ifndef ORDERED_KEY_SET_SUCCESSOR_UNIT_MACROS_SVH
`define ORDERED_KEY_SET_SUCCESSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/oks_pkg.sv]
// Constants, codes and bit-search helpers for the ordered key set unit.
`default_nettype none

package oks_pkg;

    localparam int KEY_SPACE = 1024;
    localparam int WORD_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int KEY_W     = $clog2(KEY_SPACE);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = KEY_SPACE / WORD_BITS;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int LIMIT_W   = KEY_W + 1;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 3;
    localparam int IN_BITS   = OP_W + KEY_W + DATA_W;
    localparam int OUT_BITS  = STAT_W + KEY_W + DATA_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [NUM_WORDS-1:0] sum_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_FIND   = 3'd2,
        OP_SUCC   = 3'd3,
        OP_PRED   = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_RANGE  = 3'd1,
        STAT_DUP    = 3'd2,
        STAT_ABSENT = 3'd3,
        STAT_NONE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORD,
        S_WORD2,
        S_RESP
    } fsm_state_t;

    // Index of the lowest set bit (zero for an empty word)
    function automatic logic [BIT_W-1:0] low_bit(input word_t v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // Index of the highest set bit (zero for an empty word)
    function automatic logic [BIT_W-1:0] high_bit(input word_t v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // Lowest set bit of the summary
    function automatic logic [WIDX_W-1:0] low_word(input sum_t v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (v[i]) r = WIDX_W'(i);
        end
        return r;
    endfunction

    // Highest set bit of the summary
    function automatic logic [WIDX_W-1:0] high_word(input sum_t v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (v[i]) r = WIDX_W'(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ordered_key_set_successor_unit.sv]
// Ordered key set with insert, delete, find, successor and predecessor.
// Steps: accept and RAM reads, update or search, a second word read when a successor or
// predecessor must hop through the summary to another presence word, result handoff.
// One item at a time: s_tready is high only in idle, and the handoff waits for the output
// register to be free. Result register lets the next item enter while one waits.
// Reset (rst_n low, async): set empty, summary cleared, key_limit = 1024.
`default_nettype none
`include "ordered_key_set_successor_unit_macros.svh"

module ordered_key_set_successor_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: key_limit
    input  wire logic                          cfg_wr_en,
    input  wire logic [oks_pkg::LIMIT_W-1:0]   cfg_wr_data,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [oks_pkg::S_TDATA_W-1:0] s_tdata,   // opcode, key, item_data, zero pad
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [oks_pkg::M_TDATA_W-1:0]      m_tdata    // status, result_key, result_data, pad
);
    import oks_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(KEY_SPACE - 1);

    // Storage
    word_t             pres_mem [NUM_WORDS];
    logic [DATA_W-1:0] pay_mem  [KEY_SPACE];
    word_t             pres_rd_reg;
    logic [DATA_W-1:0] pay_rd_reg;

    // Control and item registers
    fsm_state_t         state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic [KEY_W-1:0]   probe_reg, probe_next;
    logic               edge_none_reg, edge_none_next;
    logic               bad_reg, bad_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    sum_t               summary_reg, summary_next;
    logic [LIMIT_W-1:0] key_limit_reg, key_limit_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic               use_pay_reg, use_pay_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [KEY_W-1:0]   m_key_reg, m_key_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;

    // Memory ports
    logic               pw_we, pr_re, dw_we, dr_re;
    logic [WIDX_W-1:0]  pw_addr, pr_addr;
    word_t              pw_wdata;
    logic [KEY_W-1:0]   dw_addr, dr_addr;

    // Input fields
    logic [OP_W-1:0]    in_op;
    logic [KEY_W-1:0]   in_key;
    logic [DATA_W-1:0]  in_data;
    logic               in_xfer;
    logic [KEY_W-1:0]   in_probe;

    // Word search terms
    logic [BIT_W-1:0]   wb;
    logic [WIDX_W-1:0]  ww;
    word_t              word_eff;
    word_t              m_up, m_dn;
    sum_t               s_up, s_dn;
    logic               res_ready;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_key  = s_tdata[OP_W +: KEY_W];
    assign in_data = s_tdata[OP_W+KEY_W +: DATA_W];

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_BITS){1'b0}}, m_data_reg, m_key_reg, m_status_reg};

    // Probe key: the key itself, or its neighbor for successor/predecessor
    always_comb
    begin
        case (in_op)
            OP_SUCC: in_probe = in_key + KEY_W'(1);
            OP_PRED: in_probe = in_key - KEY_W'(1);
            default: in_probe = in_key;
        endcase
    end

    // A word whose summary bit is clear is empty, whatever the RAM holds
    assign wb       = probe_reg[BIT_W-1:0];
    assign ww       = probe_reg[KEY_W-1:BIT_W];
    assign word_eff = summary_reg[widx_reg] ? pres_rd_reg : '0;
    assign m_up     = word_eff & (word_t'('1) << wb);
    assign m_dn     = word_eff & (word_t'('1) >> (BIT_W'(WORD_BITS - 1) - wb));
    assign s_up     = summary_reg & ((sum_t'('1) << ww) << 1);
    assign s_dn     = summary_reg & ((sum_t'('1) >> (WIDX_W'(NUM_WORDS - 1) - ww)) >> 1);
    assign res_ready = !m_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) state_next = S_WORD;
            end
            S_WORD:
            begin
                state_next = S_RESP;
                if (!bad_reg && !edge_none_reg)
                begin
                    if (op_reg == OP_SUCC && m_up == '0 && s_up != '0)
                        state_next = S_WORD2;
                    if (op_reg == OP_PRED && m_dn == '0 && s_dn != '0)
                        state_next = S_WORD2;
                end
            end
            S_WORD2: state_next = S_RESP;
            S_RESP:
            begin
                if (res_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        data_next       = data_reg;
        probe_next      = probe_reg;
        edge_none_next  = edge_none_reg;
        bad_next        = bad_reg;
        widx_next       = widx_reg;
        summary_next    = summary_reg;
        key_limit_next  = cfg_wr_en ? cfg_wr_data : key_limit_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        use_pay_next    = use_pay_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_data_next     = m_data_reg;
        pw_we    = 1'b0;
        pw_addr  = ww;
        pw_wdata = word_eff;
        pr_re    = 1'b0;
        pr_addr  = in_probe[KEY_W-1:BIT_W];
        dw_we    = 1'b0;
        dw_addr  = key_reg;
        dr_re    = 1'b0;
        dr_addr  = in_key;

        case (state_reg)
            // Take the item, start the word and payload reads
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next        = in_op;
                    key_next       = in_key;
                    data_next      = in_data;
                    probe_next     = in_probe;
                    widx_next      = in_probe[KEY_W-1:BIT_W];
                    edge_none_next = (in_op == OP_SUCC && in_key == KEY_MAX) ||
                                     (in_op == OP_PRED && in_key == '0);
                    bad_next       = (in_op > OP_PRED) || !({1'b0, in_key} < key_limit_reg);
                    pr_re          = 1'b1;
                    dr_re          = 1'b1;
                end
            end
            // Word in hand: update or search
            S_WORD:
            begin
                res_status_next = STAT_OK;
                res_key_next    = key_reg;
                use_pay_next    = 1'b0;
                if (bad_reg)
                begin
                    res_status_next = STAT_RANGE;
                end
                else
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (word_eff[wb])
                            begin
                                res_status_next = STAT_DUP;
                            end
                            else
                            begin
                                pw_we            = 1'b1;
                                pw_wdata         = word_eff | (word_t'(1) << wb);
                                dw_we            = 1'b1;
                                summary_next[ww] = 1'b1;
                            end
                        end
                        OP_DELETE, OP_FIND:
                        begin
                            if (!word_eff[wb])
                            begin
                                res_status_next = STAT_ABSENT;
                            end
                            else
                            begin
                                use_pay_next = 1'b1;
                                if (op_reg == OP_DELETE)
                                begin
                                    pw_we            = 1'b1;
                                    pw_wdata         = word_eff & ~(word_t'(1) << wb);
                                    summary_next[ww] = (pw_wdata != '0);
                                end
                            end
                        end
                        OP_SUCC:
                        begin
                            if (edge_none_reg)
                            begin
                                res_status_next = STAT_NONE;
                            end
                            else if (m_up != '0)
                            begin
                                res_key_next = {ww, low_bit(m_up)};
                                dr_addr      = res_key_next;
                                dr_re        = 1'b1;
                                use_pay_next = 1'b1;
                            end
                            else if (s_up != '0)
                            begin
                                widx_next = low_word(s_up);
                                pr_addr   = widx_next;
                                pr_re     = 1'b1;
                            end
                            else
                            begin
                                res_status_next = STAT_NONE;
                            end
                        end
                        OP_PRED:
                        begin
                            if (edge_none_reg)
                            begin
                                res_status_next = STAT_NONE;
                            end
                            else if (m_dn != '0)
                            begin
                                res_key_next = {ww, high_bit(m_dn)};
                                dr_addr      = res_key_next;
                                dr_re        = 1'b1;
                                use_pay_next = 1'b1;
                            end
                            else if (s_dn != '0)
                            begin
                                widx_next = high_word(s_dn);
                                pr_addr   = widx_next;
                                pr_re     = 1'b1;
                            end
                            else
                            begin
                                res_status_next = STAT_NONE;
                            end
                        end
                        default: res_status_next = STAT_RANGE;
                    endcase
                end
            end
            // Nearest occupied word reached through the summary
            S_WORD2:
            begin
                if (op_reg == OP_SUCC)
                    res_key_next = {widx_reg, low_bit(word_eff)};
                else
                    res_key_next = {widx_reg, high_bit(word_eff)};
                dr_addr      = res_key_next;
                dr_re        = 1'b1;
                use_pay_next = 1'b1;
            end
            // Hand the result to the output register
            S_RESP:
            begin
                if (res_ready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_data_next   = use_pay_reg ? pay_rd_reg : '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            summary_reg   <= '0;
            key_limit_reg <= LIMIT_W'(KEY_SPACE);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            summary_reg   <= summary_next;
            key_limit_reg <= key_limit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Item and result registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        data_reg       <= data_next;
        probe_reg      <= probe_next;
        edge_none_reg  <= edge_none_next;
        bad_reg        <= bad_next;
        widx_reg       <= widx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        use_pay_reg    <= use_pay_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_data_reg     <= m_data_next;
    end

    // Presence-word RAM
    always_ff @(posedge clk)
    begin
        if (pw_we) pres_mem[pw_addr] <= pw_wdata;
        if (pr_re) pres_rd_reg <= pres_mem[pr_addr];
    end

    // Payload RAM
    always_ff @(posedge clk)
    begin
        if (dw_we) pay_mem[dw_addr] <= data_reg;
        if (dr_re) pay_rd_reg <= pay_mem[dr_addr];
    end

    // Checks
    `OKS_ASSERT_NEXT(a_accept_to_word, in_xfer, state_reg == S_WORD,
                     "accepted item did not start")
    `OKS_ASSERT_NOW(a_pres_port_excl, pw_we, !pr_re,
                    "presence RAM read and write together")
    `OKS_ASSERT_NEXT(a_summary_tracks, pw_we,
                     summary_reg[$past(pw_addr)] == ($past(pw_wdata) != '0),
                     "summary bit out of step with its word")
    `OKS_ASSERT_NOW(a_fail_no_data,
                    (state_reg == S_RESP) && (res_status_reg != STAT_OK), !use_pay_reg,
                    "failed operation returns payload")

endmodule

`default_nettype wire
